/* hdl/ttc_pkg.sv */
`default_nettype none
package ttc_pkg;

  // Default size of the circular delay store, in samples.
  localparam int DELAY_DEPTH_DEF = 4096;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 24;
  localparam int DELAY_W    = 20;
  localparam int MIX_W      = 15;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Width of the whole sample part of a tap delay (base plus modulation).
  localparam int WHOLE_W = DELAY_W + 1 - FRAC_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DEPTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX      = 3'd5;

  // Register values after reset.
  localparam logic [STEP_W-1:0]  RST_PHASE_STEP   = 24'd58787;
  localparam logic [DELAY_W-1:0] RST_FIRST_BASE   = 20'd122880;
  localparam logic [DELAY_W-1:0] RST_SECOND_BASE  = 20'd208896;
  localparam logic [DELAY_W-1:0] RST_FIRST_DEPTH  = 20'd35328;
  localparam logic [DELAY_W-1:0] RST_SECOND_DEPTH = 20'd26496;
  localparam logic [MIX_W-1:0]   RST_WET_MIX      = 15'd8192;

  // Stage strobes for the tap address pipeline.
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic mod_en;
    logic adr_en;
  } ttc_tap_ctl_t;

  // Stage strobes for the interpolation and mix datapath.
  typedef struct packed {
    logic cap_new;
    logic tap_en;
    logic tap_sel;
    logic prod_en;
  } ttc_mix_ctl_t;

endpackage
`default_nettype wire

/* hdl/two_tap_chorus_effect.sv */
// Each request runs a fixed stage sequence from acceptance to its registered result;
// a new request is taken only once the last one is done, as the sequence holds four
// reads through the single read port of the delay store and the stages around them.
// A stalled result holds the sequencer in its last stage until it drains.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// phase and write position; store entries not yet written read as zero.
`default_nettype none
module two_tap_chorus_effect #(
  parameter int DELAY_DEPTH = ttc_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ttc_pkg::SAMPLE_W-1:0]    in_sample_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [ttc_pkg::SAMPLE_W-1:0]    out_sample_out,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ttc_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADD  = 4'd1;
  localparam logic [3:0] ST_MOD  = 4'd2;
  localparam logic [3:0] ST_ADR  = 4'd3;
  localparam logic [3:0] ST_RD0  = 4'd4;
  localparam logic [3:0] ST_RD1  = 4'd5;
  localparam logic [3:0] ST_RD2  = 4'd6;
  localparam logic [3:0] ST_RD3  = 4'd7;
  localparam logic [3:0] ST_INT2 = 4'd8;
  localparam logic [3:0] ST_MIX1 = 4'd9;
  localparam logic [3:0] ST_MIX2 = 4'd10;

  logic [3:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   phase_step_r;
  logic [DELAY_W-1:0]  base1_r, base2_r, depth1_r, depth2_r;
  logic [MIX_W-1:0]    wet_mix_r;
  logic [PHASE_W-1:0]  phase_r;
  logic [AW-1:0]       wpos_r;
  logic                wrapped_r;
  logic [SAMPLE_W-1:0] dry_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                rd_ok_r;
  logic                in_acc;
  logic                out_free;
  logic                mem_we;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] ram_q;
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       a1_new, a1_old, a2_new, a2_old;
  logic [FRAC_W-1:0]   frac1, frac2;
  logic [SAMPLE_W-1:0] mix_result;
  ttc_tap_ctl_t        tap_ctl;
  ttc_mix_ctl_t        mix_ctl;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign mem_we    = (state_r == ST_INT2);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= RST_PHASE_STEP;
      base1_r      <= RST_FIRST_BASE;
      base2_r      <= RST_SECOND_BASE;
      depth1_r     <= RST_FIRST_DEPTH;
      depth2_r     <= RST_SECOND_DEPTH;
      wet_mix_r    <= RST_WET_MIX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP:   phase_step_r <= cfg_data[STEP_W-1:0];
        CFG_FIRST_BASE:   base1_r      <= cfg_data[DELAY_W-1:0];
        CFG_SECOND_BASE:  base2_r      <= cfg_data[DELAY_W-1:0];
        CFG_FIRST_DEPTH:  depth1_r     <= cfg_data[DELAY_W-1:0];
        CFG_SECOND_DEPTH: depth2_r     <= cfg_data[DELAY_W-1:0];
        CFG_WET_MIX:      wet_mix_r    <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer for one request.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_ADR;
      ST_ADR:  state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_INT2;
      ST_INT2: state_nxt = ST_MIX1;
      ST_MIX1: state_nxt = ST_MIX2;
      ST_MIX2: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Dry sample of the current request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r <= in_sample_in;
    end
  end

  // Phase, write position and the flag that the store has been filled once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      wpos_r    <= '0;
      wrapped_r <= 1'b0;
    end else if (mem_we) begin
      phase_r <= phase_r + {{(PHASE_W-STEP_W){1'b0}}, phase_step_r};
      if (wpos_r == AW'(DELAY_DEPTH - 1)) begin
        wpos_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wpos_r <= wpos_r + 1'b1;
      end
    end
  end

  // Tap address pipelines.
  always_comb begin
    tap_ctl.mul_en = in_acc;
    tap_ctl.add_en = (state_r == ST_ADD);
    tap_ctl.mod_en = (state_r == ST_MOD);
    tap_ctl.adr_en = (state_r == ST_ADR);
  end

  ttc_tap #(.DEPTH(DELAY_DEPTH)) u_tap1 (
    .clk      (clk),
    .ctl      (tap_ctl),
    .ramp     (phase_r[PHASE_W-1:16]),
    .base     (base1_r),
    .depth    (depth1_r),
    .wpos     (wpos_r),
    .addr_new (a1_new),
    .addr_old (a1_old),
    .frac     (frac1)
  );

  // The second LFO runs half an LFO period ahead.
  ttc_tap #(.DEPTH(DELAY_DEPTH)) u_tap2 (
    .clk      (clk),
    .ctl      (tap_ctl),
    .ramp     ({~phase_r[PHASE_W-1], phase_r[PHASE_W-2:16]}),
    .base     (base2_r),
    .depth    (depth2_r),
    .wpos     (wpos_r),
    .addr_new (a2_new),
    .addr_old (a2_old),
    .frac     (frac2)
  );

  // Read address for each of the four store reads.
  always_comb begin
    case (state_r)
      ST_RD1:  rd_addr = a1_old;
      ST_RD2:  rd_addr = a2_new;
      ST_RD3:  rd_addr = a2_old;
      default: rd_addr = a1_new;
    endcase
  end

  // Entries not yet written since reset read as zero.
  always_ff @(posedge clk) begin
    rd_ok_r <= wrapped_r || (rd_addr < wpos_r);
  end

  ttc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wpos_r),
    .wdata (dry_r),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign rd_data = rd_ok_r ? ram_q : '0;

  // Interpolation and blend.
  always_comb begin
    mix_ctl.cap_new = (state_r == ST_RD1) || (state_r == ST_RD3);
    mix_ctl.tap_en  = (state_r == ST_RD2) || (state_r == ST_INT2);
    mix_ctl.tap_sel = (state_r == ST_INT2);
    mix_ctl.prod_en = (state_r == ST_MIX1);
  end

  ttc_mix u_mix (
    .clk         (clk),
    .ctl         (mix_ctl),
    .rd_data     (rd_data),
    .frac_first  (frac1),
    .frac_second (frac2),
    .dry         (dry_r),
    .wet_mix     (wet_mix_r),
    .result      (mix_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_MIX2) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_MIX2) && out_free) begin
      out_data_r <= mix_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
`default_nettype wire

/* hdl/ttc_ram.sv */
`default_nettype none
module ttc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/ttc_tap.sv */
`default_nettype none
module ttc_tap #(
  parameter int DEPTH = ttc_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire ttc_pkg::ttc_tap_ctl_t         ctl,
  input  wire logic [15:0]                   ramp,
  input  wire logic [ttc_pkg::DELAY_W-1:0]   base,
  input  wire logic [ttc_pkg::DELAY_W-1:0]   depth,
  input  wire logic [$clog2(DEPTH)-1:0]      wpos,
  output logic      [$clog2(DEPTH)-1:0]      addr_new,
  output logic      [$clog2(DEPTH)-1:0]      addr_old,
  output logic      [ttc_pkg::FRAC_W-1:0]    frac
);
  import ttc_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  // Six halving steps bring any whole delay below a store size of 128 or more.
  localparam int NSTEP = 6;
  localparam int RW    = AW + NSTEP;

  logic [14:0]            tri_val;
  logic [15:0]            lfo;
  logic [DELAY_W+15:0]    prod_r;
  logic [DELAY_W:0]       delay_r;
  logic [RW-1:0]          red;
  logic [AW-1:0]          whole_r;
  logic [FRAC_W-1:0]      frac_r;
  logic [AW:0]            diff;
  logic [AW-1:0]          anew;
  logic [AW-1:0]          anew_r;
  logic [AW-1:0]          aold_r;

  // Triangle from the top half of the phase; the result is odd, 1 to 65535.
  always_comb begin
    tri_val = ramp[15] ? ~ramp[14:0] : ramp[14:0];
    lfo     = {tri_val, 1'b1};
  end

  // Depth times LFO, registered before the add.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= depth * lfo;
    end
  end

  // Q8 delay of this tap.
  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      delay_r <= {1'b0, base} + {1'b0, prod_r[DELAY_W+15:16]};
    end
  end

  // Whole samples modulo the store size by restoring subtraction.
  always_comb begin
    red = RW'(delay_r[DELAY_W:FRAC_W]);
    for (int k = NSTEP - 1; k >= 0; k--) begin
      if (red >= (RW'(DEPTH) << k)) begin
        red = red - (RW'(DEPTH) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mod_en) begin
      whole_r <= red[AW-1:0];
      frac_r  <= delay_r[FRAC_W-1:0];
    end
  end

  // Newer and older entry addresses behind the write position.
  always_comb begin
    if (wpos >= whole_r) begin
      diff = {1'b0, wpos} - {1'b0, whole_r};
    end else begin
      diff = {1'b0, wpos} + (AW+1)'(DEPTH) - {1'b0, whole_r};
    end
    anew = diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.adr_en) begin
      anew_r <= anew;
      aold_r <= (anew == '0) ? AW'(DEPTH - 1) : anew - 1'b1;
    end
  end

  assign addr_new = anew_r;
  assign addr_old = aold_r;
  assign frac     = frac_r;

endmodule
`default_nettype wire

/* hdl/ttc_mix.sv */
`default_nettype none
module ttc_mix (
  input  wire logic                          clk,
  input  wire ttc_pkg::ttc_mix_ctl_t         ctl,
  input  wire logic [ttc_pkg::SAMPLE_W-1:0]  rd_data,
  input  wire logic [ttc_pkg::FRAC_W-1:0]    frac_first,
  input  wire logic [ttc_pkg::FRAC_W-1:0]    frac_second,
  input  wire logic [ttc_pkg::SAMPLE_W-1:0]  dry,
  input  wire logic [ttc_pkg::MIX_W-1:0]     wet_mix,
  output logic      [ttc_pkg::SAMPLE_W-1:0]  result
);
  import ttc_pkg::*;

  logic signed [SAMPLE_W-1:0] newer_r;
  logic signed [SAMPLE_W-1:0] tap1_r;
  logic signed [SAMPLE_W-1:0] tap2_r;
  logic        [FRAC_W-1:0]   frac;
  logic        [FRAC_W:0]     w_new;
  logic signed [25:0]         interp;
  logic signed [SAMPLE_W:0]   tap_sum;
  logic signed [SAMPLE_W-1:0] wet;
  logic        [15:0]         dry_w;
  logic signed [32:0]         pdry_r;
  logic signed [31:0]         pwet_r;
  logic signed [33:0]         mix_sum;
  logic signed [18:0]         mixed;

  // Hold the newer entry until the older one arrives.
  always_ff @(posedge clk) begin
    if (ctl.cap_new) begin
      newer_r <= $signed(rd_data);
    end
  end

  // Linear interpolation between the two entries, floored to whole units.
  always_comb begin
    frac   = ctl.tap_sel ? frac_second : frac_first;
    w_new  = 9'd256 - {1'b0, frac};
    interp = newer_r * $signed({1'b0, w_new})
           + $signed(rd_data) * $signed({2'b00, frac});
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_en) begin
      if (ctl.tap_sel) begin
        tap2_r <= interp[23:8];
      end else begin
        tap1_r <= interp[23:8];
      end
    end
  end

  // Average of the taps and the two weighted products.
  always_comb begin
    tap_sum = {tap1_r[SAMPLE_W-1], tap1_r} + {tap2_r[SAMPLE_W-1], tap2_r};
    wet     = tap_sum[SAMPLE_W:1];
    dry_w   = 16'd32768 - {1'b0, wet_mix};
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      pdry_r <= $signed(dry) * $signed({1'b0, dry_w});
      pwet_r <= wet * $signed({1'b0, wet_mix});
    end
  end

  // Sum, floor by 2^15 and saturate.
  always_comb begin
    mix_sum = {pdry_r[32], pdry_r} + {{2{pwet_r[31]}}, pwet_r};
    mixed   = mix_sum[33:15];
    if (mixed > 19'sd32767) begin
      result = 16'h7fff;
    end else if (mixed < -19'sd32768) begin
      result = 16'h8000;
    end else begin
      result = mixed[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire
